>>> sv/mrgba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrgba_pkg
// Shared types, constants and helpers for the masked 24-bit to RGBA8 unpacker.
// ----------------------------------------------------------------------------
package mrgba_pkg;

	localparam int PIX_W  = 24;
	localparam int MASK_W = 32;
	localparam int SH_W   = 5;
	localparam int CH_W   = 8;
	localparam int NUM_W  = 34;
	localparam int DEN_W  = 33;
	localparam int CMP_W  = DEN_W + CH_W;
	localparam int CFG_IDX_W = 3;

	// three front stages plus one stage per quotient bit
	localparam int LANE_STAGES = 3 + CH_W;

	localparam logic [CH_W-1:0] CH_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_RED   = 3'd0,
		REG_MASK_GREEN = 3'd1,
		REG_MASK_BLUE  = 3'd2,
		REG_MASK_ALPHA = 3'd3,
		REG_LUMINANCE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic            zero;
		logic [CH_W-1:0] q;
	} lane_res_t;

	function automatic logic [SH_W-1:0] trail_zeros(input logic [MASK_W-1:0] m);
		logic [SH_W-1:0] n;
		n = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				n = SH_W'(i);
			end
		end
		return n;
	endfunction

endpackage

>>> sv/mrgba_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrgba_lane
// One channel datapath: field extract, numerator build, then a restoring
// divider with one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module mrgba_lane (
	input  logic                             clk,
	input  logic                             adv,
	input  logic [mrgba_pkg::PIX_W-1:0]      pixel,
	input  logic [mrgba_pkg::MASK_W-1:0]     mask,
	output mrgba_pkg::lane_res_t             res
);

	localparam int CH_W = mrgba_pkg::CH_W;

	logic [mrgba_pkg::PIX_W-1:0]  pix_s1;
	logic [mrgba_pkg::MASK_W-1:0] mask_s1;
	logic [mrgba_pkg::SH_W-1:0]   tz_s1;
	logic                         zero_s1;

	logic [mrgba_pkg::PIX_W-1:0]  val_s2;
	logic [mrgba_pkg::MASK_W-1:0] max_s2;
	logic                         zero_s2;

	logic [mrgba_pkg::NUM_W-1:0]  num_s3;
	logic [mrgba_pkg::DEN_W-1:0]  den_s3;
	logic                         zero_s3;

	logic [mrgba_pkg::NUM_W-1:0]  div_rem_s  [0:CH_W-1];
	logic [mrgba_pkg::DEN_W-1:0]  div_den_s  [0:CH_W-1];
	logic [CH_W-1:0]              div_quo_s  [0:CH_W-1];
	logic                         div_zero_s [0:CH_W-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= pixel & mask[mrgba_pkg::PIX_W-1:0];
			mask_s1 <= mask;
			tz_s1   <= mrgba_pkg::trail_zeros(mask);
			zero_s1 <= (mask == '0);

			val_s2  <= pix_s1 >> tz_s1;
			max_s2  <= mask_s1 >> tz_s1;
			zero_s2 <= zero_s1;

			// value*510 + max
			num_s3  <= mrgba_pkg::NUM_W'({val_s2, 9'b0})
			         - mrgba_pkg::NUM_W'({val_s2, 1'b0})
			         + mrgba_pkg::NUM_W'(max_s2);
			den_s3  <= {max_s2, 1'b0};
			zero_s3 <= zero_s2;
		end
	end

	for (genvar k = 0; k < CH_W; k++) begin : g_div
		logic [mrgba_pkg::NUM_W-1:0] rem_in;
		logic [mrgba_pkg::DEN_W-1:0] den_in;
		logic [CH_W-1:0]             quo_in;
		logic                        zero_in;
		logic [mrgba_pkg::CMP_W-1:0] den_sh;
		logic [mrgba_pkg::CMP_W-1:0] rem_ext;
		logic                        take;

		if (k == 0) begin : g_first
			assign rem_in  = num_s3;
			assign den_in  = den_s3;
			assign quo_in  = '0;
			assign zero_in = zero_s3;
		end else begin : g_next
			assign rem_in  = div_rem_s[k-1];
			assign den_in  = div_den_s[k-1];
			assign quo_in  = div_quo_s[k-1];
			assign zero_in = div_zero_s[k-1];
		end

		assign den_sh  = mrgba_pkg::CMP_W'(den_in) << (CH_W - 1 - k);
		assign rem_ext = mrgba_pkg::CMP_W'(rem_in);
		assign take    = (rem_ext >= den_sh);

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k]  <= take ? mrgba_pkg::NUM_W'(rem_ext - den_sh) : rem_in;
				div_den_s[k]  <= den_in;
				div_quo_s[k]  <= quo_in | (CH_W'(take) << (CH_W - 1 - k));
				div_zero_s[k] <= zero_in;
			end
		end
	end

	assign res.zero = div_zero_s[CH_W-1];
	assign res.q    = div_quo_s[CH_W-1];

endmodule

>>> sv/masked_rgb24_to_rgba8.sv
`timescale 1ns / 1ps
// Pipeline: 3 front stages (field extract, numerator build) and 8 divider
// stages, one quotient bit each, between input accept and result valid.
// Throughput: one item per cycle; the whole pipe stalls together when the
// output item is not taken.
// Reset: arst_n clears the valid bits and all configuration registers to 0.
// ----------------------------------------------------------------------------
// masked_rgb24_to_rgba8
// Unpacks a masked 24-bit pixel into four scaled 8-bit channels.
// ----------------------------------------------------------------------------
module masked_rgb24_to_rgba8 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [mrgba_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mrgba_pkg::MASK_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mrgba_pkg::PIX_W-1:0]         source_pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mrgba_pkg::CH_W-1:0]          red_out,
	output logic [mrgba_pkg::CH_W-1:0]          green_out,
	output logic [mrgba_pkg::CH_W-1:0]          blue_out,
	output logic [mrgba_pkg::CH_W-1:0]          alpha_out
);

	localparam int NS = mrgba_pkg::LANE_STAGES;

	logic [mrgba_pkg::MASK_W-1:0] mask_red_q;
	logic [mrgba_pkg::MASK_W-1:0] mask_green_q;
	logic [mrgba_pkg::MASK_W-1:0] mask_blue_q;
	logic [mrgba_pkg::MASK_W-1:0] mask_alpha_q;
	logic                         lum_q;

	logic         vld_s   [1:NS];
	logic         cp_g_s  [1:NS];
	logic         cp_b_s  [1:NS];
	logic         adv;

	mrgba_pkg::lane_res_t res_r, res_g, res_b, res_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_red_q   <= '0;
			mask_green_q <= '0;
			mask_blue_q  <= '0;
			mask_alpha_q <= '0;
			lum_q        <= 1'b0;
		end else if (cfg_wen) begin
			unique case (mrgba_pkg::cfg_reg_t'(cfg_idx))
				mrgba_pkg::REG_MASK_RED:   mask_red_q   <= cfg_wdata;
				mrgba_pkg::REG_MASK_GREEN: mask_green_q <= cfg_wdata;
				mrgba_pkg::REG_MASK_BLUE:  mask_blue_q  <= cfg_wdata;
				mrgba_pkg::REG_MASK_ALPHA: mask_alpha_q <= cfg_wdata;
				mrgba_pkg::REG_LUMINANCE:  lum_q        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign adv       = !vld_s[NS] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= NS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_g_s[1] <= lum_q || (mask_green_q == '0);
			cp_b_s[1] <= lum_q || (mask_blue_q == '0);
			for (int i = 2; i <= NS; i++) begin
				cp_g_s[i] <= cp_g_s[i-1];
				cp_b_s[i] <= cp_b_s[i-1];
			end
		end
	end

	mrgba_lane u_lane_r (.clk(clk), .adv(adv), .pixel(source_pixel), .mask(mask_red_q),
		.res(res_r));
	mrgba_lane u_lane_g (.clk(clk), .adv(adv), .pixel(source_pixel), .mask(mask_green_q),
		.res(res_g));
	mrgba_lane u_lane_b (.clk(clk), .adv(adv), .pixel(source_pixel), .mask(mask_blue_q),
		.res(res_b));
	mrgba_lane u_lane_a (.clk(clk), .adv(adv), .pixel(source_pixel), .mask(mask_alpha_q),
		.res(res_a));

	assign red_out   = res_r.zero ? '0 : res_r.q;
	assign green_out = cp_g_s[NS] ? red_out : (res_g.zero ? '0 : res_g.q);
	assign blue_out  = cp_b_s[NS] ? red_out : (res_b.zero ? '0 : res_b.q);
	assign alpha_out = res_a.zero ? mrgba_pkg::CH_MAX : res_a.q;

endmodule

>>> sim/masked_rgb24_to_rgba8_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_rgb24_to_rgba8_tb
// Self-checking bench for the masked pixel unpacker. A queue-fed driver sends
// 24-bit pixels and a monitor takes the RGBA8 results. A local scaler works out
// each expected result when its pixel is accepted. Mask settings change only
// while the pipe is empty. Both sides stall at random, except in one
// back-to-back phase.
// ----------------------------------------------------------------------------
module masked_rgb24_to_rgba8_tb;

	localparam int PIX_W          = mrgba_pkg::PIX_W;
	localparam int MASK_W         = mrgba_pkg::MASK_W;
	localparam int CH_W           = mrgba_pkg::CH_W;
	localparam int CFG_IDX_W      = mrgba_pkg::CFG_IDX_W;
	localparam int DRAIN_CYCLES   = mrgba_pkg::LANE_STAGES + 4;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int STALL_PCT      = 31;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} rgba_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx      = '0;
	logic [MASK_W-1:0]    cfg_wdata    = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     source_pixel = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [CH_W-1:0]      red_out;
	logic [CH_W-1:0]      green_out;
	logic [CH_W-1:0]      blue_out;
	logic [CH_W-1:0]      alpha_out;

	logic [PIX_W-1:0]  pixel_q[$];
	rgba_t             rgba_expected_q[$];
	logic [MASK_W-1:0] reg_shadow [5];
	logic              steady_flow = 1'b0;
	rgba_t             want_px;
	rgba_t             got_px;
	int                fail_count    = 0;
	int                item_count    = 0;
	int                result_count  = 0;
	int                setting_count = 0;
	int                idle_cycles   = 0;

	masked_rgb24_to_rgba8 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_pixel (source_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.alpha_out    (alpha_out)
	);

	always #1 clk = ~clk;

	function automatic logic [CH_W-1:0] scale_field(input logic [PIX_W-1:0] pix,
		input logic [MASK_W-1:0] mask);
		int          sh;
		logic [63:0] top;
		logic [63:0] val;
		logic [63:0] q;
		if (mask == '0) begin
			return '0;
		end
		sh = 0;
		while (sh < 31 && !mask[sh]) begin
			sh++;
		end
		top = 64'(mask >> sh);
		val = 64'((32'(pix) & mask) >> sh);
		q = (val * 64'd510 + top) / (64'd2 * top);
		if (q > 64'd255) begin
			q = 64'd255;
		end
		return q[CH_W-1:0];
	endfunction

	function automatic rgba_t unpack_pixel(input logic [PIX_W-1:0] pix);
		rgba_t res;
		logic  lum;
		lum = reg_shadow[mrgba_pkg::REG_LUMINANCE][0];
		res.r = scale_field(pix, reg_shadow[mrgba_pkg::REG_MASK_RED]);
		res.g = (lum || reg_shadow[mrgba_pkg::REG_MASK_GREEN] == '0) ? res.r :
			scale_field(pix, reg_shadow[mrgba_pkg::REG_MASK_GREEN]);
		res.b = (lum || reg_shadow[mrgba_pkg::REG_MASK_BLUE] == '0) ? res.r :
			scale_field(pix, reg_shadow[mrgba_pkg::REG_MASK_BLUE]);
		res.a = (reg_shadow[mrgba_pkg::REG_MASK_ALPHA] == '0) ? mrgba_pkg::CH_MAX :
			scale_field(pix, reg_shadow[mrgba_pkg::REG_MASK_ALPHA]);
		return res;
	endfunction

	function automatic logic [MASK_W-1:0] rand_mask();
		int          w;
		int          pos;
		logic [63:0] field;
		case ($urandom_range(9)) inside
			0: return '0;
			1: return $urandom;
			2: return 32'h1 << $urandom_range(31);
			3: return '1;
			4, 5: begin
				w = $urandom_range(1, 32);
				pos = $urandom_range(0, 32 - w);
				field = ((64'h1 << w) - 64'h1) << pos;
				return field[MASK_W-1:0];
			end
			default: begin
				w = $urandom_range(1, 12);
				pos = $urandom_range(0, PIX_W - w);
				field = ((64'h1 << w) - 64'h1) << pos;
				return field[MASK_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic queue_pixel(input logic [PIX_W-1:0] pix);
		pixel_q = {pixel_q, pix};
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			source_pixel <= '0;
		end else begin
			if (in_valid && in_ready) begin
				rgba_expected_q = {rgba_expected_q, unpack_pixel(pixel_q[0])};
				void'(pixel_q.pop_front());
				item_count++;
			end
			if (!in_valid || in_ready) begin
				if (pixel_q.size() != 0 &&
					(steady_flow || $urandom_range(99) >= STALL_PCT)) begin
					in_valid <= 1'b1;
					source_pixel <= pixel_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				got_px = '{red_out, green_out, blue_out, alpha_out};
				if (rgba_expected_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected item: r=%02h g=%02h b=%02h a=%02h",
							got_px.r, got_px.g, got_px.b, got_px.a);
					end
					fail_count++;
				end else begin
					want_px = rgba_expected_q.pop_front();
					if (got_px.r !== want_px.r || got_px.g !== want_px.g ||
						got_px.b !== want_px.b || got_px.a !== want_px.a) begin
						if (fail_count < 10) begin
							$write("mismatch item %0d: exp r=%02h g=%02h b=%02h a=%02h,",
								result_count, want_px.r, want_px.g, want_px.b,
								want_px.a);
							$display(" got r=%02h g=%02h b=%02h a=%02h",
								got_px.r, got_px.g, got_px.b, got_px.a);
						end
						fail_count++;
					end
				end
			end
			out_ready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input mrgba_pkg::cfg_reg_t idx, input logic [MASK_W-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		reg_shadow[idx] = data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [MASK_W-1:0] mr, input logic [MASK_W-1:0] mg,
		input logic [MASK_W-1:0] mb, input logic [MASK_W-1:0] ma, input logic lum);
		write_reg(mrgba_pkg::REG_MASK_RED, mr);
		write_reg(mrgba_pkg::REG_MASK_GREEN, mg);
		write_reg(mrgba_pkg::REG_MASK_BLUE, mb);
		write_reg(mrgba_pkg::REG_MASK_ALPHA, ma);
		// upper bits of the luminance write are don't-care
		write_reg(mrgba_pkg::REG_LUMINANCE, {31'($urandom), lum});
		setting_count++;
	endtask

	task automatic drain();
		while (pixel_q.size() != 0 || rgba_expected_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < 5; i++) begin
			reg_shadow[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset masks: red zero, copies zero, alpha opaque
		queue_pixel(24'h000000);
		queue_pixel(24'hFFFFFF);
		queue_pixel(24'h123456);
		drain();

		// byte lanes, no alpha mask
		apply_setting(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'h0, 1'b0);
		queue_pixel(24'h000000);
		queue_pixel(24'hFFFFFF);
		queue_pixel(24'h80C040);
		drain();

		// 565 plus high-byte alpha
		apply_setting(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h00FF_0000, 1'b0);
		queue_pixel(24'h000000);
		queue_pixel(24'hFFFFFF);
		queue_pixel(24'h5A5A5A);
		queue_pixel(24'hA5A5A5);
		drain();

		// mask bits above the pixel width
		apply_setting(32'hFFFF_FFFF, 32'hFF00_0000, 32'h8000_0000, 32'h00FF_FFFF, 1'b0);
		queue_pixel(24'hFFFFFF);
		queue_pixel(24'h000001);
		queue_pixel(24'h800000);
		drain();

		// luminance overrides green and blue; one-bit alpha
		apply_setting(32'h0080_0000, 32'h0000_FF00, 32'h00FF_0000, 32'h0000_0001, 1'b1);
		queue_pixel(24'h800001);
		queue_pixel(24'h7FFFFE);
		queue_pixel(24'hFFFFFF);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			apply_setting(rand_mask(), rand_mask(), rand_mask(), rand_mask(),
				$urandom_range(3) == 0);
			steady_flow = (ph == 5);
			for (int n = 0; n < 100; n++) begin
				queue_pixel(rand_pixel());
			end
			drain();
		end
		steady_flow = 1'b0;

		apply_setting('1, '1, '1, '1, 1'b0);
		for (int n = 0; n < 20; n++) begin
			queue_pixel(rand_pixel());
		end
		drain();

		if (rgba_expected_q.size() != 0) begin
			fail_count++;
		end
		$display("covered %0d pixels and %0d results over %0d mask settings",
			item_count, result_count, setting_count);
		$display("mismatches: %0d", fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/mrgba_pkg.sv
sv/mrgba_lane.sv
sv/masked_rgb24_to_rgba8.sv
sim/masked_rgb24_to_rgba8_tb.sv
